[design/vector_normalizer_core_defines.svh]
// assertion helpers used by vector_normalizer_core
`ifndef VECTOR_NORMALIZER_CORE_DEFINES_SVH
`define VECTOR_NORMALIZER_CORE_DEFINES_SVH

// checked only outside reset
`define VN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");

// checked at every edge, reset included
`define VN_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

[design/vn_pkg.sv]
`default_nettype none
package vn_pkg;
  localparam int COMPONENT_WIDTH = 32;
  localparam int LANES = 4;
  localparam int OUT_WIDTH = 32;
  localparam int OUT_FRAC = 30;
  localparam int SQ_WIDTH = 2 * COMPONENT_WIDTH;
  localparam int SUM_WIDTH = SQ_WIDTH + 1;
  localparam int DIV_STEPS = 2 * OUT_FRAC + 1;
  localparam int Q_WIDTH = DIV_STEPS;
  localparam int SQRT_STEPS = OUT_FRAC + 1;
  localparam int MAG_WIDTH = OUT_FRAC + 1;
  localparam int CC_WIDTH = 3;
  localparam logic [CC_WIDTH-1:0] CC_THREE = 3'd3;
  localparam logic [CC_WIDTH-1:0] CC_RESET = 3'd4;

  typedef struct packed {
    logic valid;
    logic neg;
    logic zero;
  } side_t;
endpackage
`default_nettype wire

[design/vector_normalizer_core.sv]
// channel   direction  handshake             payload
// input     in         in_valid / in_stall   comp_x comp_y comp_z comp_w
// output    out        out_valid / out_stall unit_x unit_y unit_z unit_w zero_length
// config    in         cfg_we                cfg_data (component_count)
//
// one request per cycle unless a result is stalled; the pipeline holds two front
// stages, the sum stage, 61 divider stages, 31 root stages and the output register.
// rst is synchronous and clears every valid bit; component_count resets to 4.
// a stalled result freezes the whole pipeline and in_stall rises with it.
`default_nettype none
`include "vector_normalizer_core_defines.svh"
module vector_normalizer_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [vn_pkg::COMPONENT_WIDTH-1:0] comp_x,
  input  wire logic signed [vn_pkg::COMPONENT_WIDTH-1:0] comp_y,
  input  wire logic signed [vn_pkg::COMPONENT_WIDTH-1:0] comp_z,
  input  wire logic signed [vn_pkg::COMPONENT_WIDTH-1:0] comp_w,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [vn_pkg::OUT_WIDTH-1:0]      unit_x,
  output logic signed [vn_pkg::OUT_WIDTH-1:0]      unit_y,
  output logic signed [vn_pkg::OUT_WIDTH-1:0]      unit_z,
  output logic signed [vn_pkg::OUT_WIDTH-1:0]      unit_w,
  output logic                                     zero_length,
  input  wire logic                                cfg_we,
  input  wire logic [vn_pkg::CC_WIDTH-1:0]         cfg_data
);
  logic [vn_pkg::CC_WIDTH-1:0]        component_count;
  logic                               en;
  logic [1:0]                         front_valid;
  logic [vn_pkg::COMPONENT_WIDTH-1:0] comp   [vn_pkg::LANES];
  logic                               used   [vn_pkg::LANES];
  logic [vn_pkg::SQ_WIDTH-1:0]        sq     [vn_pkg::LANES];
  logic                               neg    [vn_pkg::LANES];
  logic [vn_pkg::SQ_WIDTH-1:0]        msq    [vn_pkg::LANES];
  logic [vn_pkg::SUM_WIDTH-1:0]       sum;
  vn_pkg::side_t                      mside  [vn_pkg::LANES];
  logic [vn_pkg::MAG_WIDTH-1:0]       mag    [vn_pkg::LANES];
  vn_pkg::side_t                      lside  [vn_pkg::LANES];
  logic [vn_pkg::OUT_WIDTH-1:0]       unit_next [vn_pkg::LANES];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      component_count <= vn_pkg::CC_RESET;
    end else if (cfg_we) begin
      component_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= '0;
    end else if (en) begin
      front_valid <= {front_valid[0], in_valid};
    end
  end

  assign comp[0] = comp_x;
  assign comp[1] = comp_y;
  assign comp[2] = comp_z;
  assign comp[3] = comp_w;
  assign used[0] = 1'b1;
  assign used[1] = 1'b1;
  assign used[2] = 1'b1;
  assign used[3] = (component_count != vn_pkg::CC_THREE);

  for (genvar i = 0; i < vn_pkg::LANES; i++) begin : g_sq
    vn_square u_square (
      .clk  (clk),
      .en   (en),
      .used (used[i]),
      .comp (comp[i]),
      .sq   (sq[i]),
      .neg  (neg[i])
    );
  end

  vn_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (front_valid[1]),
    .sq_in    (sq),
    .neg_in   (neg),
    .sq_out   (msq),
    .sum      (sum),
    .side     (mside)
  );

  for (genvar i = 0; i < vn_pkg::LANES; i++) begin : g_lane
    vn_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .sq       (msq[i]),
      .sum      (sum),
      .side_in  (mside[i]),
      .mag      (mag[i]),
      .side_out (lside[i])
    );
    // zero length: divider output is meaningless, force zero
    assign unit_next[i] = lside[i].zero ? '0 :
                          lside[i].neg  ? (~{1'b0, mag[i]} + 1'b1) : {1'b0, mag[i]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= lside[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_x      <= unit_next[0];
      unit_y      <= unit_next[1];
      unit_z      <= unit_next[2];
      unit_w      <= unit_next[3];
      zero_length <= lside[0].zero;
    end
  end

  `VN_ASSERT(a_zero_outputs, out_valid && zero_length |-> (unit_x | unit_y | unit_z | unit_w) == 0)
  `VN_ASSERT(a_unit_range, out_valid |-> unit_x <= 32'sh4000_0000 && unit_x >= -32'sh4000_0000)
  `VN_ASSERT_ALWAYS(a_hold_result, !rst && out_valid && out_stall |=> rst || out_valid)
endmodule
`default_nettype wire

[design/vn_square.sv]
`default_nettype none
module vn_square (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic                                  used,
  input  wire logic [vn_pkg::COMPONENT_WIDTH-1:0]    comp,
  output logic      [vn_pkg::SQ_WIDTH-1:0]           sq,
  output logic                                       neg
);
  logic [vn_pkg::COMPONENT_WIDTH-1:0] mag;
  logic                               neg_a;
  logic                               used_a;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a  <= comp[vn_pkg::COMPONENT_WIDTH-1];
      mag    <= comp[vn_pkg::COMPONENT_WIDTH-1] ? (~comp + 1'b1) : comp;
      used_a <= used;
      neg    <= neg_a;
      // an unused lane contributes nothing and divides to zero
      sq     <= used_a ? (vn_pkg::SQ_WIDTH'(mag) * vn_pkg::SQ_WIDTH'(mag))
                       : '0;
    end
  end
endmodule
`default_nettype wire

[design/vn_merge.sv]
`default_nettype none
module vn_merge (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          valid_in,
  input  wire logic [vn_pkg::SQ_WIDTH-1:0]   sq_in  [vn_pkg::LANES],
  input  wire logic                          neg_in [vn_pkg::LANES],
  output logic      [vn_pkg::SQ_WIDTH-1:0]   sq_out [vn_pkg::LANES],
  output logic      [vn_pkg::SUM_WIDTH-1:0]  sum,
  output vn_pkg::side_t                      side   [vn_pkg::LANES]
);
  logic [vn_pkg::SUM_WIDTH-1:0] sum_next;
  logic                         valid;
  logic                         zero;
  logic                         neg    [vn_pkg::LANES];

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < vn_pkg::LANES; i++) begin
      sum_next = sum_next + vn_pkg::SUM_WIDTH'(sq_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum  <= sum_next;
      zero <= (sum_next == '0);
      for (int i = 0; i < vn_pkg::LANES; i++) begin
        sq_out[i] <= sq_in[i];
        neg[i]    <= neg_in[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < vn_pkg::LANES; i++) begin
      side[i].valid = valid;
      side[i].neg   = neg[i];
      side[i].zero  = zero;
    end
  end
endmodule
`default_nettype wire

[design/vn_lane.sv]
`default_nettype none
module vn_lane (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic [vn_pkg::SQ_WIDTH-1:0]    sq,
  input  wire logic [vn_pkg::SUM_WIDTH-1:0]   sum,
  input  vn_pkg::side_t                       side_in,
  output logic      [vn_pkg::MAG_WIDTH-1:0]   mag,
  output vn_pkg::side_t                       side_out
);
  localparam int DS = vn_pkg::DIV_STEPS;
  localparam int SS = vn_pkg::SQRT_STEPS;
  localparam int QW = vn_pkg::Q_WIDTH;

  // restoring divider: floor(c^2 * 2^60 / sum), one quotient bit a stage
  logic [vn_pkg::SUM_WIDTH-1:0] dr   [0:DS];
  logic [QW-1:0]                dq   [0:DS];
  logic [vn_pkg::SUM_WIDTH-1:0] dsum [0:DS];
  vn_pkg::side_t                dsd  [0:DS];

  // square root: one result bit a stage
  logic [QW-1:0]                sv   [0:SS];
  logic [QW-1:0]                sres [0:SS];
  vn_pkg::side_t                ssd  [0:SS];

  assign dr[0]   = vn_pkg::SUM_WIDTH'(sq);
  assign dq[0]   = '0;
  assign dsum[0] = sum;
  assign dsd[0]  = side_in;

  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [vn_pkg::SUM_WIDTH:0] trial;
    logic                       take;
    assign trial = (k == 0) ? {1'b0, dr[k]} : {dr[k], 1'b0};
    assign take  = (trial >= {1'b0, dsum[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dsd[k+1].valid <= 1'b0;
      end else if (en) begin
        dsd[k+1].valid <= dsd[k].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr[k+1]       <= take ? vn_pkg::SUM_WIDTH'(trial - {1'b0, dsum[k]})
                              : vn_pkg::SUM_WIDTH'(trial);
        dq[k+1]       <= {dq[k][QW-2:0], take};
        dsum[k+1]     <= dsum[k];
        dsd[k+1].neg  <= dsd[k].neg;
        dsd[k+1].zero <= dsd[k].zero;
      end
    end
  end

  assign sv[0]   = dq[DS];
  assign sres[0] = '0;
  assign ssd[0]  = dsd[DS];

  for (genvar j = 0; j < SS; j++) begin : g_sqrt
    localparam logic [QW-1:0] BIT = QW'(1) << (QW - 1 - 2 * j);
    logic [QW:0] cand;
    logic        take;
    assign cand = {1'b0, sres[j]} + {1'b0, BIT};
    assign take = ({1'b0, sv[j]} >= cand);

    always_ff @(posedge clk) begin
      if (rst) begin
        ssd[j+1].valid <= 1'b0;
      end else if (en) begin
        ssd[j+1].valid <= ssd[j].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sv[j+1]       <= take ? QW'({1'b0, sv[j]} - cand) : sv[j];
        sres[j+1]     <= take ? ((sres[j] >> 1) + BIT) : (sres[j] >> 1);
        ssd[j+1].neg  <= ssd[j].neg;
        ssd[j+1].zero <= ssd[j].zero;
      end
    end
  end

  assign mag      = sres[SS][vn_pkg::MAG_WIDTH-1:0];
  assign side_out = ssd[SS];
endmodule
`default_nettype wire
